// ===== hdl/cdf_pkg.sv =====
// Shared types and constants for the CRC16 packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package cdf_pkg;

    localparam logic [7:0]  START_MARK = 8'h01;
    localparam logic [7:0]  COLON_MARK = 8'h3A;
    localparam logic [7:0]  END_MARK   = 8'h17;
    localparam logic [15:0] CRC_POLY   = 16'h8D95;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [9:0]  MIN_BUFFER = 10'd7;
    localparam logic [8:0]  POS_MAX    = 9'd511;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_CRC_FAIL  = 2'd3
    } t_status;

    // One buffered input byte.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_rx_item;

endpackage

`default_nettype wire

// ===== hdl/cdf_crc_byte.sv =====
// Reflected CRC16 update by one byte, eight bit steps unrolled.
`timescale 1ns / 1ps
`default_nettype none

module cdf_crc_byte (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_data,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_data};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ cdf_pkg::CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

`default_nettype wire

// ===== hdl/cdf_parser.sv =====
// Frame state tracking, status decision and result register.
`timescale 1ns / 1ps
`default_nettype none

module cdf_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    input  wire cdf_pkg::t_rx_item i_item,
    output logic                   o_take,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_payload_valid,
    output logic       [7:0]       o_payload_byte,
    output logic       [7:0]       o_payload_index,
    output logic                   o_done_res,
    output logic       [1:0]       o_status,
    output logic       [7:0]       o_payload_length
);

    logic [8:0]  r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic        r_hdr_bad, n_hdr_bad;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic        r_crc_bad, n_crc_bad;
    logic        r_end_bad, n_end_bad;

    logic        r_out_valid;
    logic        r_pv, n_pv;
    logic [7:0]  r_pb, n_pb;
    logic [7:0]  r_pi, n_pi;
    logic        r_done, n_done;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_plen, n_plen;

    logic [15:0] w_crc_next;
    logic [9:0]  w_pos_ext;
    logic [9:0]  w_len_ext;
    logic [9:0]  w_count;
    logic [8:0]  w_idx;

    cdf_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_data (i_item.rx_byte),
        .o_crc  (w_crc_next)
    );

    assign o_take    = i_item_valid && (!r_out_valid || i_out_ready);
    assign w_pos_ext = {1'b0, r_pos};
    assign w_len_ext = {2'b00, r_len};
    assign w_idx     = r_pos - 9'd3;
    assign w_count   = w_pos_ext + 10'd1;

    always_comb begin
        cdf_pkg::t_status v_st;
        n_pos     = r_pos;
        n_len     = r_len;
        n_hdr_bad = r_hdr_bad;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        n_crc_bad = r_crc_bad;
        n_end_bad = r_end_bad;
        n_pv      = 1'b0;
        n_pb      = 8'h00;
        n_pi      = 8'h00;
        n_done    = 1'b0;
        n_status  = cdf_pkg::ST_OK;
        n_plen    = 8'h00;
        v_st      = cdf_pkg::ST_OK;

        if (r_pos == 9'd0) begin
            if (i_item.rx_byte != cdf_pkg::START_MARK) n_hdr_bad = 1'b1;
        end else if (r_pos == 9'd1) begin
            n_len = i_item.rx_byte;
        end else if (r_pos == 9'd2) begin
            if (i_item.rx_byte != cdf_pkg::COLON_MARK) n_hdr_bad = 1'b1;
        end else if (w_pos_ext < w_len_ext + 10'd3) begin
            n_crc = w_crc_next;
            if (!r_hdr_bad) begin
                n_pv = 1'b1;
                n_pb = i_item.rx_byte;
                n_pi = w_idx[7:0];
            end
        end else if (w_pos_ext == w_len_ext + 10'd3) begin
            n_crc_lo = i_item.rx_byte;
        end else if (w_pos_ext == w_len_ext + 10'd4) begin
            n_crc_bad = ({i_item.rx_byte, r_crc_lo} != r_crc);
        end else if (w_pos_ext == w_len_ext + 10'd5) begin
            n_end_bad = (i_item.rx_byte != cdf_pkg::END_MARK);
        end

        if (r_pos < cdf_pkg::POS_MAX) n_pos = r_pos + 9'd1;

        if (i_item.last_byte) begin
            n_done = 1'b1;
            // checks in priority order
            if (w_count < cdf_pkg::MIN_BUFFER) begin
                v_st = cdf_pkg::ST_SHORT;
            end else if (n_hdr_bad) begin
                v_st = cdf_pkg::ST_MALFORMED;
            end else if (w_count < {2'b00, n_len} + 10'd6) begin
                v_st = cdf_pkg::ST_MALFORMED;
            end else if (n_crc_bad) begin
                v_st = cdf_pkg::ST_CRC_FAIL;
            end else if (n_end_bad) begin
                v_st = cdf_pkg::ST_MALFORMED;
            end else begin
                v_st   = cdf_pkg::ST_OK;
                n_plen = n_len;
            end
            n_status = v_st;
            // back to idle for the next buffer
            n_pos     = 9'd0;
            n_len     = 8'h00;
            n_hdr_bad = 1'b0;
            n_crc     = cdf_pkg::CRC_INIT;
            n_crc_lo  = 8'h00;
            n_crc_bad = 1'b0;
            n_end_bad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 9'd0;
            r_len       <= 8'h00;
            r_hdr_bad   <= 1'b0;
            r_crc       <= cdf_pkg::CRC_INIT;
            r_crc_lo    <= 8'h00;
            r_crc_bad   <= 1'b0;
            r_end_bad   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_pos     <= n_pos;
                r_len     <= n_len;
                r_hdr_bad <= n_hdr_bad;
                r_crc     <= n_crc;
                r_crc_lo  <= n_crc_lo;
                r_crc_bad <= n_crc_bad;
                r_end_bad <= n_end_bad;
            end
            r_out_valid <= o_take || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pv     <= n_pv;
            r_pb     <= n_pb;
            r_pi     <= n_pi;
            r_done   <= n_done;
            r_status <= n_status;
            r_plen   <= n_plen;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_valid  = r_pv;
    assign o_payload_byte   = r_pb;
    assign o_payload_index  = r_pi;
    assign o_done_res       = r_done;
    assign o_status         = r_status;
    assign o_payload_length = r_plen;

endmodule

`default_nettype wire

// ===== hdl/crc16_packet_deframer.sv =====
// Top level of the CRC16 length-prefixed packet deframer.
//
//  channel  direction  handshake                    payload
//  input    in         i_in_valid / o_in_ready      i_rx_byte, i_last_byte
//  result   out        o_out_valid / i_out_ready    o_payload_valid, o_payload_byte,
//                                                   o_payload_index, o_done_res,
//                                                   o_status, o_payload_length
//
// One byte per cycle sustained while the result side is ready; each byte passes
// through the input register, then the result register after the parse and CRC step.
// Every byte yields exactly one result. Reset (synchronous, active low) empties
// both registers and returns the frame state to idle. When the result side
// stalls, the input register holds one byte and then ready drops.
`timescale 1ns / 1ps
`default_nettype none

module crc16_packet_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_payload_valid,
    output logic      [7:0] o_payload_byte,
    output logic      [7:0] o_payload_index,
    output logic            o_done_res,
    output logic      [1:0] o_status,
    output logic      [7:0] o_payload_length
);

    logic              r_in_valid;
    cdf_pkg::t_rx_item r_in_item;
    logic              w_take;

    assign o_in_ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item.rx_byte   <= i_rx_byte;
            r_in_item.last_byte <= i_last_byte;
        end
    end

    cdf_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (r_in_valid),
        .i_item           (r_in_item),
        .o_take           (w_take),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_valid  (o_payload_valid),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_done_res       (o_done_res),
        .o_status         (o_status),
        .o_payload_length (o_payload_length)
    );

endmodule

`default_nettype wire

// ===== tb/sv/deframer_scoreboard_pkg.sv =====
// Scoreboard, result type and CRC helper for the CRC16 packet deframer testbench.
`timescale 1ns / 1ps

package deframer_scoreboard_pkg;

    import cdf_pkg::*;

    // Everything the block reports for one input byte.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       done_res;
        t_status    status;
        logic [7:0] payload_length;
    } t_byte_result;

    // Reflected CRC16, one byte at a time.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    class deframer_scoreboard;

        // Parser state, tracked byte by byte.
        logic [8:0]   position;
        logic [7:0]   frame_len;
        logic         header_bad;
        logic [15:0]  payload_crc;
        logic [7:0]   crc_low;
        logic         crc_bad;
        logic         end_bad;

        t_byte_result results_due[$];
        int unsigned  mismatches;
        int unsigned  status_seen[4];
        int unsigned  buffers_seen;

        function new();
            clear_frame();
            mismatches   = 0;
            buffers_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void clear_frame();
            position    = '0;
            frame_len   = '0;
            header_bad  = 1'b0;
            payload_crc = CRC_INIT;
            crc_low     = '0;
            crc_bad     = 1'b0;
            end_bad     = 1'b0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // Parse one transferred byte and queue the result it must produce.
        function void accept_byte(input logic [7:0] b, input logic last);
            t_byte_result r;
            int unsigned  p;
            int unsigned  n;
            r = '0;
            p = position;
            if (p == 0) begin
                if (b != START_MARK) header_bad = 1'b1;
            end else if (p == 1) begin
                frame_len = b;
            end else if (p == 2) begin
                if (b != COLON_MARK) header_bad = 1'b1;
            end else if (p < 3 + frame_len) begin
                payload_crc = crc16_step(payload_crc, b);
                if (!header_bad) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = 8'(p - 3);
                end
            end else if (p == 3 + frame_len) begin
                crc_low = b;
            end else if (p == 4 + frame_len) begin
                crc_bad = ({b, crc_low} != payload_crc);
            end else if (p == 5 + frame_len) begin
                end_bad = (b != END_MARK);
            end

            if (position < POS_MAX) position++;

            if (last) begin
                n          = p + 1;
                r.done_res = 1'b1;
                if (n < MIN_BUFFER)
                    r.status = ST_SHORT;
                else if (header_bad || n < frame_len + 6)
                    r.status = ST_MALFORMED;
                else if (crc_bad)
                    r.status = ST_CRC_FAIL;
                else if (end_bad)
                    r.status = ST_MALFORMED;
                else begin
                    r.status         = ST_OK;
                    r.payload_length = frame_len;
                end
                status_seen[r.status]++;
                buffers_seen++;
                clear_frame();
            end
            results_due.push_back(r);
        endfunction

        function void report(input string what, input t_byte_result got,
                             input t_byte_result want);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH (%s) at %0t: got pv=%0b byte=%02h idx=%0d done=%0b st=%0d len=%0d, expected pv=%0b byte=%02h idx=%0d done=%0b st=%0d len=%0d",
                         what, $time,
                         got.payload_valid, got.payload_byte, got.payload_index,
                         got.done_res, got.status, got.payload_length,
                         want.payload_valid, want.payload_byte, want.payload_index,
                         want.done_res, want.status, want.payload_length);
        endfunction

        function void check_result(input t_byte_result got);
            t_byte_result want;
            string        fields;
            if (results_due.size() == 0) begin
                report("no result expected", got, '0);
                return;
            end
            want   = results_due.pop_front();
            fields = "";
            if (got.payload_valid  !== want.payload_valid)  fields = {fields, " payload_valid"};
            if (got.payload_byte   !== want.payload_byte)   fields = {fields, " payload_byte"};
            if (got.payload_index  !== want.payload_index)  fields = {fields, " payload_index"};
            if (got.done_res       !== want.done_res)       fields = {fields, " done_res"};
            if (got.status         !== want.status)         fields = {fields, " status"};
            if (got.payload_length !== want.payload_length) fields = {fields, " payload_length"};
            if (fields != "") report({"field", fields}, got, want);
        endfunction

    endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench for the CRC16 packet deframer: frame stimulus, handshakes and checking.
`timescale 1ns / 1ps

module testbench;

    import cdf_pkg::*;
    import deframer_scoreboard_pkg::*;

    typedef enum {
        FR_GOOD,
        FR_SHORT,
        FR_BAD_START,
        FR_BAD_COLON,
        FR_TRUNCATED,
        FR_BAD_CRC,
        FR_BAD_END,
        FR_NOISE
    } t_frame_kind;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       out_pv;
    logic [7:0] out_pb;
    logic [7:0] out_pi;
    logic       out_done;
    logic [1:0] out_status;
    logic [7:0] out_len;

    deframer_scoreboard sb = new();

    logic [7:0]  buf_q[$];
    bit          send_idle = 1'b0;
    bit          recv_idle = 1'b0;
    int          hold_len  = 0;
    int unsigned bytes_sent = 0;

    crc16_packet_deframer uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_last_byte      (last_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_payload_valid  (out_pv),
        .o_payload_byte   (out_pb),
        .o_payload_index  (out_pi),
        .o_done_res       (out_done),
        .o_status         (out_status),
        .o_payload_length (out_len)
    );

    always #4 clk = ~clk;

    // Result monitor: every transfer on the output side is checked.
    always @(posedge clk) begin : result_monitor
        t_byte_result got;
        if (rst_n && out_valid && out_ready) begin
            got.payload_valid  = out_pv;
            got.payload_byte   = out_pb;
            got.payload_index  = out_pi;
            got.done_res       = out_done;
            got.status         = t_status'(out_status);
            got.payload_length = out_len;
            sb.check_result(got);
        end
    end

    // Result receiver: random stall per result, or one long hold when requested.
    initial begin : receiver
        int stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = recv_idle ? $urandom_range(0, 3) : 0;
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        #2_000_000;
        $display("crc16_packet_deframer verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        sb.accept_byte(b, last);
        bytes_sent++;
    endtask

    // Valid stays high between buffers; it drops only for idle gaps and in drain_results.
    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++)
            send_byte(buf_q[i], i == buf_q.size() - 1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() > 0);
    endtask

    task automatic make_frame(input t_frame_kind kind, input int len, input int trailing,
                              input bit extremes);
        logic [15:0] crc;
        logic [7:0]  b;
        int          keep;
        buf_q.delete();
        crc = CRC_INIT;
        if (kind == FR_NOISE) begin
            repeat (len) buf_q.push_back(8'($urandom));
            return;
        end
        b = START_MARK;
        if (kind == FR_BAD_START) while (b == START_MARK) b = 8'($urandom);
        buf_q.push_back(b);
        buf_q.push_back(8'(len));
        b = COLON_MARK;
        if (kind == FR_BAD_COLON) while (b == COLON_MARK) b = 8'($urandom);
        buf_q.push_back(b);
        for (int i = 0; i < len; i++) begin
            b   = extremes ? {8{i[0]}} : 8'($urandom);
            crc = crc16_step(crc, b);
            buf_q.push_back(b);
        end
        if (kind == FR_BAD_CRC) crc ^= 16'd1 << $urandom_range(0, 15);
        buf_q.push_back(crc[7:0]);
        buf_q.push_back(crc[15:8]);
        b = END_MARK;
        if (kind == FR_BAD_END) while (b == END_MARK) b = 8'($urandom);
        buf_q.push_back(b);
        repeat (trailing) buf_q.push_back(8'($urandom));
        if (kind == FR_SHORT)
            keep = $urandom_range(1, 6);
        else if (kind == FR_TRUNCATED)
            keep = $urandom_range(3, len + 5);
        else
            keep = buf_q.size();
        while (buf_q.size() > keep) void'(buf_q.pop_back());
    endtask

    // Mostly well-formed frames with small payloads; the rest broken or noise.
    task automatic random_frames(input int unsigned byte_budget);
        int unsigned spent;
        int          pick;
        int          len;
        int          trailing;
        t_frame_kind kind;
        spent = 0;
        while (spent < byte_budget) begin
            if ($urandom_range(0, 7) == 0) begin
                send_idle = $urandom_range(0, 3) != 0;
                recv_idle = $urandom_range(0, 3) != 0;
            end
            pick = $urandom_range(0, 99);
            if      (pick < 55) kind = FR_GOOD;
            else if (pick < 61) kind = FR_SHORT;
            else if (pick < 67) kind = FR_BAD_START;
            else if (pick < 73) kind = FR_BAD_COLON;
            else if (pick < 80) kind = FR_TRUNCATED;
            else if (pick < 87) kind = FR_BAD_CRC;
            else if (pick < 93) kind = FR_BAD_END;
            else                kind = FR_NOISE;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            if (kind == FR_NOISE) len = $urandom_range(1, 14);
            trailing = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            make_frame(kind, len, trailing, 1'b0);
            send_buffer();
            spent += buf_q.size();
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames, first without idling, then with it.
        make_frame(FR_GOOD, 0, 1, 1'b0);      send_buffer();  // empty payload, just long enough
        make_frame(FR_GOOD, 0, 0, 1'b0);      send_buffer();  // empty payload, buffer too short
        make_frame(FR_NOISE, 1, 0, 1'b0);     send_buffer();  // single-byte buffer
        make_frame(FR_GOOD, 1, 0, 1'b0);      send_buffer();
        make_frame(FR_GOOD, 4, 0, 1'b1);      send_buffer();  // payload 00/FF
        send_idle = 1'b1;
        recv_idle = 1'b1;
        make_frame(FR_BAD_START, 3, 0, 1'b0); send_buffer();
        make_frame(FR_BAD_COLON, 3, 0, 1'b0); send_buffer();
        make_frame(FR_TRUNCATED, 8, 0, 1'b0); send_buffer();
        make_frame(FR_BAD_CRC, 4, 0, 1'b0);   send_buffer();
        make_frame(FR_BAD_END, 2, 0, 1'b0);   send_buffer();
        make_frame(FR_GOOD, 3, 3, 1'b1);      send_buffer();  // trailing bytes ignored
        drain_results();

        random_frames(40);
        drain_results();

        // Long receiver hold while the sender keeps going: fills the pipe.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_len  = 48;
        make_frame(FR_GOOD, 30, 0, 1'b0);     send_buffer();
        drain_results();

        // Largest payload.
        send_idle = 1'b1;
        recv_idle = 1'b1;
        make_frame(FR_GOOD, 255, 0, 1'b0);    send_buffer();
        drain_results();

        random_frames(20);
        drain_results();
        repeat (10) @(posedge clk);

        $display("Run covered %0d buffers and %0d bytes, with a 255-byte payload",
                 sb.buffers_seen, bytes_sent);
        $display("and a full-stall hold: ok %0d, short %0d, malformed %0d, crc %0d, %0d mismatches",
                 sb.status_seen[ST_OK], sb.status_seen[ST_SHORT],
                 sb.status_seen[ST_MALFORMED], sb.status_seen[ST_CRC_FAIL], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("crc16_packet_deframer verification clean");
        else
            $display("crc16_packet_deframer verification failed");
        $finish;
    end

endmodule
